// ----- rtl/ptw_pkg.sv -----
// Shared types, codes and constants of the page-table walker.
package ptw_pkg;

  localparam int LEVELS_DEF    = 4;
  localparam int PHYS_BITS_DEF = 52;

  // Fixed by the entry and address formats.
  localparam int INDEX_BITS = 9;
  localparam int PAGE_SHIFT = 12;
  localparam int FIELD_BITS = 52;
  localparam int VA_BITS    = 48;
  localparam int ENTRY_BITS = 64;
  localparam int PRESENT_POS = 0;
  localparam int SIZE_POS    = 7;

  localparam logic [ENTRY_BITS-1:0] OFF_4K = (64'd1 << PAGE_SHIFT) - 64'd1;
  localparam logic [ENTRY_BITS-1:0] OFF_2M = (64'd1 << (PAGE_SHIFT + INDEX_BITS)) - 64'd1;
  localparam logic [ENTRY_BITS-1:0] OFF_1G = (64'd1 << (PAGE_SHIFT + 2 * INDEX_BITS)) - 64'd1;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_RESPONSE  = 1'b1;

  localparam logic KIND_READ   = 1'b0;
  localparam logic KIND_RESULT = 1'b1;

  localparam logic [1:0] PK_4K = 2'd0;
  localparam logic [1:0] PK_2M = 2'd1;
  localparam logic [1:0] PK_1G = 2'd2;

  typedef struct packed {
    logic                  kind;
    logic [FIELD_BITS-1:0] entry_address;
    logic [FIELD_BITS-1:0] physical_address;
    logic                  fault;
    logic [1:0]            page_kind;
  } ptw_result_t;

endpackage

// ----- rtl/ptw_walk.sv -----
// Walk state and the per-request decision: next read, translation or fault.
module ptw_walk #(
  parameter int LEVELS    = ptw_pkg::LEVELS_DEF,
  parameter int PHYS_BITS = ptw_pkg::PHYS_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ptw_pkg::FIELD_BITS-1:0]      cfg_root_table_base,
  input  logic                                accept,
  input  logic                                opcode,
  input  logic [ptw_pkg::VA_BITS-1:0]         virtual_address,
  input  logic [ptw_pkg::ENTRY_BITS-1:0]      read_data,
  output logic                                res_valid,
  output ptw_pkg::ptw_result_t                res
);

  localparam int LVL_W = $clog2(LEVELS);
  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);
  localparam logic [ptw_pkg::ENTRY_BITS-1:0] PHYS_MASK = (64'd1 << PHYS_BITS) - 64'd1;

  logic [ptw_pkg::FIELD_BITS-1:0] root_r;
  logic                           busy_r, busy_nxt;
  logic [LVL_W-1:0]               level_r, level_nxt;
  logic [ptw_pkg::VA_BITS-1:0]    held_r, held_nxt;
  logic [PHYS_BITS-1:0]           tb_r, tb_nxt;

  // levels left below the current one; wide enough to hold 2 for any depth
  logic [2:0]                      below, below_nxt;
  logic [5:0]                      shift;
  logic [ptw_pkg::INDEX_BITS-1:0]  idx;
  logic [ptw_pkg::ENTRY_BITS-1:0]  off_mask, pa64, ea64;
  logic                            issue_read, finish;
  logic [1:0]                      pk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r  <= '0;
      busy_r  <= 1'b0;
      level_r <= '0;
      held_r  <= '0;
      tb_r    <= '0;
    end else begin
      if (cfg_we) root_r <= cfg_root_table_base;
      busy_r  <= busy_nxt;
      level_r <= level_nxt;
      held_r  <= held_nxt;
      tb_r    <= tb_nxt;
    end
  end

  assign below = 3'(LVL_TOP) - 3'(level_r);

  always_comb begin
    busy_nxt   = busy_r;
    level_nxt  = level_r;
    held_nxt   = held_r;
    tb_nxt     = tb_r;
    issue_read = 1'b0;
    finish     = 1'b0;
    pk         = ptw_pkg::PK_4K;
    off_mask   = ptw_pkg::OFF_4K;
    res_valid  = 1'b0;
    res        = '0;
    if (accept) begin
      if (opcode == ptw_pkg::OP_TRANSLATE) begin
        if (!busy_r) begin
          held_nxt   = virtual_address;
          level_nxt  = '0;
          tb_nxt     = {root_r[PHYS_BITS-1:ptw_pkg::PAGE_SHIFT], {ptw_pkg::PAGE_SHIFT{1'b0}}};
          busy_nxt   = 1'b1;
          issue_read = 1'b1;
        end
      end else if (busy_r) begin
        res_valid = 1'b1;
        if (!read_data[ptw_pkg::PRESENT_POS]) begin
          res.kind  = ptw_pkg::KIND_RESULT;
          res.fault = 1'b1;
          busy_nxt  = 1'b0;
          level_nxt = '0;
        end else if (below == '0) begin
          finish = 1'b1;
        end else if (read_data[ptw_pkg::SIZE_POS] && below <= 3'd2) begin
          finish = 1'b1;
          if (below == 3'd2) begin
            pk       = ptw_pkg::PK_1G;
            off_mask = ptw_pkg::OFF_1G;
          end else begin
            pk       = ptw_pkg::PK_2M;
            off_mask = ptw_pkg::OFF_2M;
          end
        end else begin
          tb_nxt     = {read_data[PHYS_BITS-1:ptw_pkg::PAGE_SHIFT],
                        {ptw_pkg::PAGE_SHIFT{1'b0}}};
          level_nxt  = LVL_W'(level_r + 1'b1);
          issue_read = 1'b1;
        end
      end
    end
    if (finish) begin
      res.kind             = ptw_pkg::KIND_RESULT;
      res.physical_address = pa64[ptw_pkg::FIELD_BITS-1:0];
      res.page_kind        = pk;
      busy_nxt             = 1'b0;
      level_nxt            = '0;
    end
    if (issue_read) begin
      res_valid         = 1'b1;
      res.kind          = ptw_pkg::KIND_READ;
      res.entry_address = ea64[ptw_pkg::FIELD_BITS-1:0];
    end
  end

  // large-page frame drops its address bits below the page size
  assign pa64 = ((read_data & PHYS_MASK & ~off_mask) |
                 (64'(held_r) & off_mask)) & PHYS_MASK;

  // read address built from the state that the walk moves on to
  assign below_nxt = 3'(LVL_TOP) - 3'(level_nxt);
  assign shift     = 6'(ptw_pkg::PAGE_SHIFT) + 6'(ptw_pkg::INDEX_BITS) * 6'(below_nxt);
  assign idx       = ptw_pkg::INDEX_BITS'(held_nxt >> shift);
  assign ea64      = 64'(tb_nxt) | 64'({idx, 3'b000});

endmodule

// ----- rtl/ptw_out_reg.sv -----
// Result register on the output channel, held while the receiver stalls.
module ptw_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 res_valid,
  input  ptw_pkg::ptw_result_t res,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 load_ok,
  output ptw_pkg::ptw_result_t out_data
);

  logic                 valid_r;
  ptw_pkg::ptw_result_t data_r;

  assign load_ok = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ok) begin
      valid_r <= accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) data_r <= res;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- rtl/four_level_page_table_walker_unit.sv -----
// Top level of the four-level page-table walker.
//
// Input channel (in_valid/in_stall): a request is either a translate
// (in_opcode 0, in_virtual_address) or a memory read response (in_opcode 1,
// in_read_data carrying one table entry). Output channel (out_valid/
// out_stall): each request yields at most one result, either a table-entry
// read (out_kind 0, out_entry_address) or a finished translation (out_kind 1,
// out_physical_address, out_fault, out_page_kind). A translate while a walk is
// running, or a response while idle, is dropped without a result.
// An accepted request's result enters the output register on the next clock.
// Throughput: one request per cycle unless stalled, set by the single result
// register; a walk itself costs one response per level, paced by memory.
// cfg_root_table_base is always ready; the user, not the block, must see that
// it is written only while idle. Synchronous reset clears walk, root, output.
// While the receiver stalls the result holds and in_stall rises, but a
// request can still enter in the cycle the pending result is taken.
module four_level_page_table_walker_unit #(
  parameter int LEVELS    = ptw_pkg::LEVELS_DEF,
  parameter int PHYS_BITS = ptw_pkg::PHYS_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ptw_pkg::FIELD_BITS-1:0] cfg_root_table_base,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [ptw_pkg::VA_BITS-1:0]    in_virtual_address,
  input  logic [ptw_pkg::ENTRY_BITS-1:0] in_read_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_kind,
  output logic [ptw_pkg::FIELD_BITS-1:0] out_entry_address,
  output logic [ptw_pkg::FIELD_BITS-1:0] out_physical_address,
  output logic                           out_fault,
  output logic [1:0]                     out_page_kind
);

  logic                 accept, load_ok, res_valid;
  ptw_pkg::ptw_result_t res, out_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = !load_ok;
  assign accept    = in_valid && load_ok;

  ptw_walk #(
    .LEVELS    (LEVELS),
    .PHYS_BITS (PHYS_BITS)
  ) u_walk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_root_table_base (cfg_root_table_base),
    .accept              (accept),
    .opcode              (in_opcode),
    .virtual_address     (in_virtual_address),
    .read_data           (in_read_data),
    .res_valid           (res_valid),
    .res                 (res)
  );

  ptw_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .load_ok   (load_ok),
    .out_data  (out_data)
  );

  assign out_kind             = out_data.kind;
  assign out_entry_address    = out_data.entry_address;
  assign out_physical_address = out_data.physical_address;
  assign out_fault            = out_data.fault;
  assign out_page_kind        = out_data.page_kind;

endmodule

// ----- rtl/ptw_checker.sv -----
// Port-level assertions for the page-table walker, bound to the top level.
module ptw_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_kind,
  input logic [ptw_pkg::FIELD_BITS-1:0] out_entry_address,
  input logic [ptw_pkg::FIELD_BITS-1:0] out_physical_address,
  input logic                           out_fault,
  input logic [1:0]                     out_page_kind
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_entry_address) && $stable(out_physical_address))
    else $error("stalled result changed");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a pending result");

  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ptw_pkg::KIND_READ |->
      out_entry_address[2:0] == 3'b000 && out_physical_address == '0 &&
      !out_fault && out_page_kind == ptw_pkg::PK_4K)
    else $error("malformed read request");

  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ptw_pkg::KIND_RESULT && out_fault |->
      out_physical_address == '0 && out_page_kind == ptw_pkg::PK_4K &&
      out_entry_address == '0)
    else $error("fault result carries an address");

  a_page_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_page_kind == ptw_pkg::PK_4K || out_page_kind == ptw_pkg::PK_2M ||
      out_page_kind == ptw_pkg::PK_1G)
    else $error("bad page kind");

endmodule

bind four_level_page_table_walker_unit ptw_checker u_ptw_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_kind             (out_kind),
  .out_entry_address    (out_entry_address),
  .out_physical_address (out_physical_address),
  .out_fault            (out_fault),
  .out_page_kind        (out_page_kind)
);

// ----- sim/four_level_page_table_walker_unit_tb.sv -----
// Self-checking testbench for the four-level page-table walker: directed and random walks.
module four_level_page_table_walker_unit_tb;
  import ptw_pkg::*;

  localparam int LEVELS    = LEVELS_DEF;
  localparam int PHYS_BITS = PHYS_BITS_DEF;
  localparam logic [63:0] PHYS_MASK = (64'd1 << PHYS_BITS) - 64'd1;
  localparam int QUIET_LIMIT = 4000;
  localparam int CHOKE_CYCLES = 300;

  typedef struct packed {
    logic                  op;
    logic [VA_BITS-1:0]    va;
    logic [ENTRY_BITS-1:0] data;
  } walk_req_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [FIELD_BITS-1:0] cfg_root_table_base = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_opcode = OP_TRANSLATE;
  logic [VA_BITS-1:0]    in_virtual_address = '0;
  logic [ENTRY_BITS-1:0] in_read_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_kind;
  logic [FIELD_BITS-1:0] out_entry_address;
  logic [FIELD_BITS-1:0] out_physical_address;
  logic                  out_fault;
  logic [1:0]            out_page_kind;

  walk_req_t   walk_requests[$];
  ptw_result_t due_results[$];

  int mismatches = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int choke_asks = 0;
  int choke_seen = 0;
  int gap_left = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // stimulus-side view of the walk, used only to shape sequences
  bit gen_busy = 1'b0;
  int gen_lvl = 0;

  // predicted walker state
  bit                  walker_busy = 1'b0;
  int                  walk_lvl = 0;
  logic [VA_BITS-1:0]  walk_va = '0;
  logic [63:0]         walk_base = '0;
  logic [FIELD_BITS-1:0] root_base = '0;

  four_level_page_table_walker_unit #(
    .LEVELS(LEVELS),
    .PHYS_BITS(PHYS_BITS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_root_table_base(cfg_root_table_base),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_virtual_address(in_virtual_address),
    .in_read_data(in_read_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_entry_address(out_entry_address),
    .out_physical_address(out_physical_address),
    .out_fault(out_fault),
    .out_page_kind(out_page_kind)
  );

  initial forever #1 clk = ~clk;

  function automatic ptw_result_t entry_read();
    ptw_result_t r;
    int sh;
    logic [63:0] idx;
    r = '0;
    sh = PAGE_SHIFT + INDEX_BITS * (LEVELS - 1 - walk_lvl);
    idx = (sh < 64) ? (({16'd0, walk_va} >> sh) & 64'h1FF) : 64'd0;
    r.kind = KIND_READ;
    r.entry_address = FIELD_BITS'((walk_base + (idx << 3)) & PHYS_MASK);
    return r;
  endfunction

  // Returns 1 when the request yields a result, advancing the predicted walk.
  function automatic bit next_walk_output(input logic op, input logic [VA_BITS-1:0] va,
                                          input logic [ENTRY_BITS-1:0] d,
                                          output ptw_result_t r);
    int below;
    logic [63:0] off;
    logic [1:0] pk;
    r = '0;
    if (op == OP_TRANSLATE) begin
      if (walker_busy) return 1'b0;
      walk_va = va;
      walk_lvl = 0;
      walk_base = {12'd0, root_base} & PHYS_MASK & ~OFF_4K;
      walker_busy = 1'b1;
      r = entry_read();
      return 1'b1;
    end
    if (!walker_busy) return 1'b0;
    below = LEVELS - 1 - walk_lvl;
    if (!d[PRESENT_POS]) begin
      r.kind = KIND_RESULT;
      r.fault = 1'b1;
      walker_busy = 1'b0;
      walk_lvl = 0;
      return 1'b1;
    end
    if (below == 0) begin
      off = OFF_4K;
      pk = PK_4K;
    end else if (d[SIZE_POS] && below <= 2) begin
      off = (below == 2) ? OFF_1G : OFF_2M;
      pk = (below == 2) ? PK_1G : PK_2M;
    end else begin
      walk_base = d & PHYS_MASK & ~OFF_4K;
      walk_lvl++;
      r = entry_read();
      return 1'b1;
    end
    r.kind = KIND_RESULT;
    r.physical_address = FIELD_BITS'(((d & PHYS_MASK & ~off) | ({16'd0, walk_va} & off))
                                     & PHYS_MASK);
    r.page_kind = pk;
    walker_busy = 1'b0;
    walk_lvl = 0;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    walk_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left == 0 && in_idle_pct != 0 && $urandom_range(99, 0) < in_idle_pct)
        gap_left = $urandom_range(8, 1);
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (walk_requests.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        nxt = walk_requests.pop_front();
        in_valid <= 1'b1;
        in_opcode <= nxt.op;
        in_virtual_address <= nxt.va;
        in_read_data <= nxt.data;
      end
    end
  end

  // result receiver: random stall bursts plus the occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (choke_seen != choke_asks) begin
        choke_seen = choke_asks;
        hold_left = CHOKE_CYCLES;
      end else if (hold_left == 0 && out_idle_pct != 0 &&
                   $urandom_range(99, 0) < out_idle_pct) begin
        hold_left = $urandom_range(8, 1);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    ptw_result_t want;
    ptw_result_t r;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) root_base = cfg_root_table_base;
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, kind %0d entry %h phys %h fault %0d page %0d",
                   $time, out_kind, out_entry_address, out_physical_address, out_fault,
                   out_page_kind);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("entry_address", want.entry_address, out_entry_address);
          check_field("physical_address", want.physical_address, out_physical_address);
          check_field("fault", want.fault, out_fault);
          check_field("page_kind", want.page_kind, out_page_kind);
        end
      end
      if (in_valid && !in_stall)
        if (next_walk_output(in_opcode, in_virtual_address, in_read_data, r))
          due_results.push_back(r);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [VA_BITS-1:0] rand_va();
    logic [63:0] t;
    t = {$urandom, $urandom};
    case ($urandom_range(9, 0))
      0: return '0;
      1: return '1;
      default: return t[VA_BITS-1:0];
    endcase
  endfunction

  function automatic logic [ENTRY_BITS-1:0] rand_entry(input int lvl);
    logic [63:0] e;
    int below;
    e = {$urandom, $urandom};
    below = LEVELS - 1 - lvl;
    e[PRESENT_POS] = ($urandom_range(99, 0) >= 8);
    if (below == 1 || below == 2) e[SIZE_POS] = ($urandom_range(3, 0) == 0);
    return e;
  endfunction

  function automatic logic [FIELD_BITS-1:0] rand_root();
    logic [63:0] t;
    t = {$urandom, $urandom};
    return t[FIELD_BITS-1:0];
  endfunction

  task automatic send(input logic op, input logic [VA_BITS-1:0] va,
                      input logic [ENTRY_BITS-1:0] d);
    walk_req_t q;
    int below;
    q.op = op;
    q.va = va;
    q.data = d;
    walk_requests.push_back(q);
    below = LEVELS - 1 - gen_lvl;
    if (op == OP_TRANSLATE) begin
      if (!gen_busy) begin
        gen_busy = 1'b1;
        gen_lvl = 0;
      end
    end else if (gen_busy) begin
      if (!d[PRESENT_POS] || below == 0 || (d[SIZE_POS] && below <= 2))
        gen_busy = 1'b0;
      else
        gen_lvl++;
    end
  endtask

  // Mostly well-formed walks; one request in twenty is one the walker drops.
  task automatic fill(input int n);
    int count;
    count = 0;
    @(negedge clk);
    while (count < n) begin
      if (!gen_busy) begin
        if ($urandom_range(19, 0) == 0) begin
          send(OP_RESPONSE, rand_va(), {$urandom, $urandom});
        end else begin
          send(OP_TRANSLATE, rand_va(), {$urandom, $urandom});
          count++;
        end
      end else if ($urandom_range(19, 0) == 0) begin
        send(OP_TRANSLATE, rand_va(), {$urandom, $urandom});
      end else begin
        send(OP_RESPONSE, rand_va(), rand_entry(gen_lvl));
        count++;
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (walk_requests.size() != 0 || in_valid || due_results.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_root(input logic [FIELD_BITS-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_root_table_base <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // The first half may stop mid-walk; the sender then waits for every result.
  task automatic run_phase(input int n, input int in_pct, input int out_pct, input bit choke);
    in_idle_pct <= in_pct;
    out_idle_pct <= out_pct;
    fill(n / 2);
    if (choke) choke_asks <= choke_asks + 1;
    drain();
    fill(n - n / 2);
    while (gen_busy) send(OP_RESPONSE, rand_va(), rand_entry(gen_lvl));
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed walks with the root base left at its reset value
    in_idle_pct <= 20;
    out_idle_pct <= 20;
    @(negedge clk);
    send(OP_TRANSLATE, '0, '0);
    send(OP_RESPONSE, '0, '0);                             // fault at the top
    send(OP_RESPONSE, '1, '1);                             // response while idle
    send(OP_TRANSLATE, '1, '0);
    send(OP_TRANSLATE, '0, '1);                            // translate while busy
    send(OP_RESPONSE, '0, 64'h0000_0000_0000_0081);        // size bit at top is ignored
    send(OP_RESPONSE, '0, '1);                             // 1 GiB page
    send(OP_TRANSLATE, 48'h8040_2010_0ABC, '0);
    send(OP_RESPONSE, '0, 64'h0000_0000_0012_3001);
    send(OP_RESPONSE, '0, 64'hFFF0_0000_0004_5003);
    send(OP_RESPONSE, '0, 64'h0000_000A_BCDE_F081);        // 2 MiB page
    send(OP_TRANSLATE, 48'h7FFF_FFFF_FFFF, '0);
    send(OP_RESPONSE, '0, 64'h000F_FFFF_FFFF_F001);
    send(OP_RESPONSE, '0, 64'h000F_FFFF_FFFF_F001);
    send(OP_RESPONSE, '0, 64'h000F_FFFF_FFFF_F001);
    send(OP_RESPONSE, '0, 64'h8000_0000_1234_5081);        // bit 7 at the bottom: 4 KiB
    send(OP_TRANSLATE, 48'h0000_0000_1000, '0);
    send(OP_RESPONSE, '0, 64'h1);
    send(OP_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFE);        // fault one level down
    send(OP_TRANSLATE, 48'hFEDC_BA98_7654, '0);
    send(OP_RESPONSE, '0, 64'h1);
    send(OP_RESPONSE, '0, 64'h1);
    send(OP_RESPONSE, '0, 64'h7E);                         // fault two levels down
    send(OP_TRANSLATE, 48'h0123_4567_89AB, '0);
    send(OP_RESPONSE, '0, 64'h1);
    send(OP_RESPONSE, '0, 64'h1);
    send(OP_RESPONSE, '0, 64'h1);
    send(OP_RESPONSE, '0, '0);                             // fault at the bottom
    drain();

    write_root('1);
    run_phase(300, 25, 25, 1'b0);
    write_root(rand_root());
    run_phase(300, 10, 10, 1'b1);
    write_root('0);
    run_phase(300, 0, 0, 1'b0);
    write_root(rand_root());
    run_phase(300, 40, 40, 1'b1);
    write_root(rand_root());
    run_phase(300, 15, 30, 1'b0);
    write_root(rand_root());
    run_phase(300, 0, 0, 1'b0);

    repeat (5) @(negedge clk);
    if (mismatches == 0 && due_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
